FILE: hw/rtl/pers_pkg.sv
`timescale 1ns / 1ps

package pers_pkg;

  // Operation codes carried in the func field.
  typedef enum logic [1:0] {
    FUNC_READ  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_OR    = 2'd2,
    FUNC_FIND  = 2'd3
  } func_e;

  localparam int unsigned EB_W      = 6;   // element_bits register
  localparam int unsigned MAX_EB    = 32;  // widest element
  localparam int unsigned IDX_W     = 16;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned LEN_W     = 11;
  localparam int unsigned EPW_W     = 7;   // elements per word, up to 64
  localparam int unsigned IDX_SHIFT = 24;  // reciprocal scale for index / epw
  localparam int unsigned RCP_W     = 25;
  localparam int unsigned BIT_SHIFT = 12;  // reciprocal scale for bit / element_bits
  localparam int unsigned RCP2_W    = 13;

  typedef struct packed {
    func_e              func;
    logic [IDX_W-1:0]   elem_index;
    logic [VAL_W-1:0]   elem_value;
    logic [LEN_W-1:0]   length_words;
  } in_item_t;

  typedef struct packed {
    logic [VAL_W-1:0]   elem_out;
    logic [IDX_W-1:0]   found_position;
    logic               found;
  } out_item_t;

  // Per-width packing geometry, looked up from the element_bits register.
  typedef struct packed {
    logic [EB_W-1:0]    nb;
    logic [EPW_W-1:0]   epw;
    logic [RCP_W-1:0]   rcp;
    logic [RCP2_W-1:0]  rcp2;
    logic [VAL_W-1:0]   emask;
  } geom_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_SCAN,
    ST_POS,
    ST_EXT,
    ST_OUT
  } state_e;

endpackage

FILE: hw/rtl/pers_stream_if.sv
`timescale 1ns / 1ps

interface pers_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/packed_element_row_store_core.sv
`timescale 1ns / 1ps
// Channel  Direction  Payload                                          Transaction when
// in_i     sink       func, elem_index, elem_value, length_words       valid && ready
// out_o    source     elem_out, found_position, found                  valid && ready
// cfg_i    sink       element_bits (6 bits)                            valid && ready
//
// Read, masked write and OR go through these steps from transaction to result: a multiply by a
// reciprocal, a multiply-back for the remainder with the word read, the bit offset, and the
// extract or write back through the row memory.
// A scan reads one word per cycle and stops at the first word that holds a non-zero element.
// After reset a clearing pass writes zero to all ROW_DEPTH words, one per cycle, and
// in_i.ready stays low during that pass; cfg_i is always ready.
// A finished result waits in the output register, and the next input transaction is
// taken while it waits; a stalled result only holds the block in its final state.

module packed_element_row_store_core import pers_pkg::*; #(
  parameter int unsigned ROW_DEPTH = 1024,
  parameter int unsigned WORD_BITS = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  pers_stream_if.sink   in_i,
  pers_stream_if.source out_o,
  pers_stream_if.sink   cfg_i
);

  localparam int unsigned AW = (ROW_DEPTH > 1) ? $clog2(ROW_DEPTH) : 1;
  localparam int unsigned CW = $clog2(ROW_DEPTH + 1);
  localparam int unsigned OW = $clog2(WORD_BITS);

  state_e state_q, state_d;

  // Configuration and geometry.
  logic [EB_W-1:0]      eb_q;
  geom_t                geom;
  logic [WORD_BITS-1:0] used;

  // Item registers.
  func_e                func_q;
  logic [IDX_W-1:0]     idx_q;
  logic [IDX_W-1:0]     q_q;
  logic [VAL_W-1:0]     val_q;
  logic [CW-1:0]        len_q;
  logic                 inrange_q;
  logic                 hit_q;
  logic [OW-1:0]        rem_q;
  logic [OW-1:0]        boff_q;
  logic [WORD_BITS-1:0] word_q;
  logic [IDX_W-1:0]     wprod_q;
  logic [IDX_W-1:0]     pos_q;

  // Scan and clear control.
  logic [CW-1:0]        cnt_q;
  logic                 chk_valid_q;
  logic [AW-1:0]        chk_addr_q;
  logic [AW-1:0]        wsel_q;
  logic [AW-1:0]        clr_q;

  // Output register.
  logic                 out_valid_q;
  out_item_t            out_q;
  out_item_t            out_d;

  // Memory port.
  logic                 ram_we;
  logic                 ram_re;
  logic [AW-1:0]        ram_waddr;
  logic [AW-1:0]        ram_raddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [WORD_BITS-1:0] rd_word;

  logic                 in_fire;
  logic                 out_free;
  logic                 out_load;
  logic                 chk_hit;
  logic                 scan_issue;

  logic [IDX_W+RCP_W-1:0]   q_full;
  logic [IDX_W+EPW_W-1:0]   qe_full;
  logic [OW-1:0]            rem_calc;
  logic                     inrange_calc;
  logic [WORD_BITS-1:0]     masked;
  logic [OW-1:0]            low_pos;
  logic [OW+RCP2_W-1:0]     k_full;
  logic [31:0]              wp_full;
  logic [OW+EB_W-1:0]       boff_full;
  logic [WORD_BITS-1:0]     shifted;
  logic [VAL_W-1:0]         elem_calc;
  logic [WORD_BITS-1:0]     mask_w;
  logic [WORD_BITS-1:0]     val_w;
  logic [WORD_BITS-1:0]     new_word;

  pers_geom #(
    .WORD_BITS (WORD_BITS)
  ) u_geom (
    .eb_i   (eb_q),
    .geom_o (geom),
    .used_o (used)
  );

  pers_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (ROW_DEPTH)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rd_word)
  );

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;

  // Word index is elem_index / epw, done as a multiply by a rounded-up reciprocal. With a
  // 16-bit index and at most 64 elements per word the error stays below one step.
  assign q_full       = (IDX_W+RCP_W)'(in_i.data.elem_index) * (IDX_W+RCP_W)'(geom.rcp);
  assign qe_full      = (IDX_W+EPW_W)'(q_q) * (IDX_W+EPW_W)'(geom.epw);
  assign rem_calc     = OW'(idx_q - qe_full[IDX_W-1:0]);
  assign inrange_calc = (32'(q_q) < 32'(ROW_DEPTH));

  // A word hits when any bit of its whole element slots is set.
  assign chk_hit    = chk_valid_q && (|(rd_word & used));
  assign scan_issue = (state_q == ST_SCAN) && !chk_hit && (cnt_q < len_q);

  // The first non-zero slot holds the lowest set bit of the used part of the word.
  assign masked = word_q & used;

  always_comb begin
    low_pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (masked[i]) begin
        low_pos = OW'(i);
      end
    end
  end

  // Slot number is low_pos / element_bits, again by a reciprocal.
  assign k_full    = (OW+RCP2_W)'(low_pos) * (OW+RCP2_W)'(geom.rcp2);
  assign wp_full   = 32'(wsel_q) * 32'(geom.epw);
  assign boff_full = (OW+EB_W)'(rem_q) * (OW+EB_W)'(geom.nb);

  assign shifted   = word_q >> boff_q;
  assign elem_calc = shifted[VAL_W-1:0] & geom.emask;
  assign mask_w    = WORD_BITS'(geom.emask) << boff_q;
  assign val_w     = WORD_BITS'(val_q) << boff_q;
  assign new_word  = (func_q == FUNC_WRITE) ? ((word_q & ~mask_w) | val_w)
                                            : (word_q | val_w);

  // Control sequencer.
  always_comb begin
    state_d    = state_q;
    in_i.ready = 1'b0;
    ram_re     = 1'b0;
    ram_raddr  = q_q[AW-1:0];
    ram_we     = 1'b0;
    ram_waddr  = q_q[AW-1:0];
    ram_wdata  = new_word;
    out_load   = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        if (clr_q == AW'(ROW_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          state_d = (in_i.data.func == FUNC_FIND) ? ST_SCAN : ST_DIV;
        end
      end
      ST_DIV: begin
        // An index past the row aliases here; the read is discarded later.
        ram_re  = 1'b1;
        state_d = ST_EXT;
      end
      ST_SCAN: begin
        if (chk_hit) begin
          state_d = ST_POS;
        end else if (cnt_q < len_q) begin
          ram_re    = 1'b1;
          ram_raddr = cnt_q[AW-1:0];
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_POS: begin
        state_d = ST_EXT;
      end
      ST_EXT: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          out_load = 1'b1;
          ram_we   = ((func_q == FUNC_WRITE) || (func_q == FUNC_OR)) && inrange_q;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Result selection: writes, ORs, out-of-range reads and scans without a hit give all zero.
  always_comb begin
    out_d = '0;
    if (func_q == FUNC_READ) begin
      out_d.elem_out = inrange_q ? elem_calc : '0;
    end else if (func_q == FUNC_FIND) begin
      out_d.elem_out       = hit_q ? elem_calc : '0;
      out_d.found_position = hit_q ? pos_q : '0;
      out_d.found          = hit_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      eb_q        <= EB_W'(1);
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      chk_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid) begin
        eb_q <= cfg_i.data;
      end
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + AW'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (in_fire) begin
        cnt_q       <= '0;
        chk_valid_q <= 1'b0;
      end else if (state_q == ST_SCAN) begin
        chk_valid_q <= scan_issue;
        if (scan_issue) begin
          cnt_q <= cnt_q + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      func_q <= in_i.data.func;
      idx_q  <= in_i.data.elem_index;
      val_q  <= in_i.data.elem_value & geom.emask;
      q_q    <= q_full[IDX_SHIFT +: IDX_W];
      hit_q  <= 1'b0;
      if (32'(in_i.data.length_words) > 32'(ROW_DEPTH)) begin
        len_q <= CW'(ROW_DEPTH);
      end else begin
        len_q <= CW'(in_i.data.length_words);
      end
    end
    if (state_q == ST_DIV) begin
      rem_q     <= rem_calc;
      inrange_q <= inrange_calc;
    end
    if (scan_issue) begin
      chk_addr_q <= cnt_q[AW-1:0];
    end
    if ((state_q == ST_SCAN) && chk_hit) begin
      word_q <= rd_word;
      wsel_q <= chk_addr_q;
      hit_q  <= 1'b1;
    end
    if (state_q == ST_POS) begin
      rem_q   <= OW'(k_full >> BIT_SHIFT);
      wprod_q <= wp_full[IDX_W-1:0];
    end
    if (state_q == ST_EXT) begin
      boff_q <= OW'(boff_full);
      pos_q  <= wprod_q + IDX_W'(rem_q);
      if (func_q != FUNC_FIND) begin
        word_q <= rd_word;
      end
    end
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign cfg_i.ready = 1'b1;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule

FILE: hw/rtl/pers_ram.sv
`timescale 1ns / 1ps

module pers_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic                                        re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

FILE: hw/rtl/pers_geom.sv
`timescale 1ns / 1ps

module pers_geom import pers_pkg::*; #(
  parameter int unsigned WORD_BITS = 64
) (
  input  logic [EB_W-1:0]      eb_i,
  output geom_t                geom_o,
  output logic [WORD_BITS-1:0] used_o
);

  logic [EB_W-1:0]      nb;
  logic [4:0]           sel;
  logic [EPW_W-1:0]     epw_tab  [MAX_EB];
  logic [RCP_W-1:0]     rcp_tab  [MAX_EB];
  logic [RCP2_W-1:0]    rcp2_tab [MAX_EB];
  logic [WORD_BITS-1:0] used_tab [MAX_EB];

  // Width zero acts as one bit, widths above the maximum act as the maximum.
  always_comb begin
    nb = eb_i;
    if (eb_i == '0) begin
      nb = EB_W'(1);
    end else if (eb_i > EB_W'(MAX_EB)) begin
      nb = EB_W'(MAX_EB);
    end
  end

  assign sel = 5'(nb - EB_W'(1));

  for (genvar g = 1; g <= MAX_EB; g++) begin : g_tab
    localparam int unsigned Epw  = WORD_BITS / g;
    localparam int unsigned Rcp  = ((1 << IDX_SHIFT) + Epw - 1) / Epw;
    localparam int unsigned Rcp2 = ((1 << BIT_SHIFT) + g - 1) / g;
    localparam int unsigned Used = Epw * g;
    assign epw_tab[g-1]  = EPW_W'(Epw);
    assign rcp_tab[g-1]  = RCP_W'(Rcp);
    assign rcp2_tab[g-1] = RCP2_W'(Rcp2);
    assign used_tab[g-1] = {WORD_BITS{1'b1}} >> (WORD_BITS - Used);
  end

  assign geom_o.nb    = nb;
  assign geom_o.epw   = epw_tab[sel];
  assign geom_o.rcp   = rcp_tab[sel];
  assign geom_o.rcp2  = rcp2_tab[sel];
  assign geom_o.emask = 32'hFFFF_FFFF >> (EB_W'(MAX_EB) - nb);
  assign used_o       = used_tab[sel];

endmodule

FILE: hw/rtl/pers_checker.sv
`timescale 1ns / 1ps

module pers_checker import pers_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_i,
  input logic            out_valid_i,
  input logic            out_ready_i,
  input out_item_t       out_data_i,
  input logic            cfg_valid_i,
  input logic            cfg_ready_i,
  input logic [EB_W-1:0] cfg_data_i
);

  logic [1:0]      pend_q;
  logic [EB_W-1:0] eb_q;
  logic [EB_W-1:0] nb;
  logic [VAL_W-1:0] wmask;
  logic            in_fire;
  logic            out_fire;

  assign in_fire  = in_valid_i && in_ready_i;
  assign out_fire = out_valid_i && out_ready_i;

  always_comb begin
    nb = eb_q;
    if (eb_q == '0) begin
      nb = EB_W'(1);
    end else if (eb_q > EB_W'(MAX_EB)) begin
      nb = EB_W'(MAX_EB);
    end
  end

  assign wmask = 32'hFFFF_FFFF >> (EB_W'(MAX_EB) - nb);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      eb_q   <= EB_W'(1);
    end else begin
      pend_q <= pend_q + 2'(in_fire) - 2'(out_fire);
      if (cfg_valid_i && cfg_ready_i) begin
        eb_q <= cfg_data_i;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_data_i)))
    else $error("result changed or dropped while stalled");

  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire |-> (pend_q != 2'd0))
    else $error("result transaction without a pending input transaction");

  a_found_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_data_i.found) |-> (out_data_i.elem_out != '0))
    else $error("scan hit reports a zero element");

  a_miss_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_data_i.found) |-> (out_data_i.found_position == '0))
    else $error("position set without a scan hit");

  a_elem_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ((out_data_i.elem_out & ~wmask) == '0))
    else $error("element wider than the configured element width");

endmodule

bind packed_element_row_store_core pers_checker u_pers_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data),
  .cfg_valid_i (cfg_i.valid),
  .cfg_ready_i (cfg_i.ready),
  .cfg_data_i  (cfg_i.data)
);

FILE: sim/packed_element_row_store_core_test.sv
`timescale 1ns / 1ps

module packed_element_row_store_core_test import pers_pkg::*; ();

  localparam int unsigned ROWS        = 1024;
  localparam int unsigned ITEM_TARGET = 1800;
  localparam int unsigned PHASES      = 12;
  localparam int unsigned CYCLE_LIMIT = 6_500_000;
  localparam int unsigned TAIL_CYCLES = 40;

  // Keeps its own copy of the packed row and of the element width, works out the result
  // of every accepted operation in order, and compares the block's results against them.
  class row_access_checker;
    logic [63:0]     row_words [ROWS];
    logic [EB_W-1:0] width_reg;
    out_item_t       expected_results [$];
    int unsigned     errors;

    function new();
      foreach (row_words[i]) row_words[i] = '0;
      width_reg = EB_W'(1);
      errors    = 0;
    endfunction

    // Computes the result of one operation and applies any write to the row copy.
    function out_item_t predict_access(in_item_t op);
      int unsigned nb, slots, len, woff, boff;
      logic [63:0] emask, word, field, shifted;
      out_item_t   res;
      res = '0;
      nb  = width_reg;
      // A zero width behaves as one bit, anything wider than 32 as 32 bits.
      if (nb == 0) nb = 1;
      if (nb > MAX_EB) nb = MAX_EB;
      slots = 64 / nb;
      emask = (64'd1 << nb) - 64'd1;
      if (op.func == FUNC_FIND) begin
        len = op.length_words;
        if (len > ROWS) len = ROWS;
        // Only whole slots are examined, so bits above the last slot never count.
        for (int unsigned w = 0; w < len && !res.found; w++) begin
          word = row_words[w];
          for (int unsigned k = 0; k < slots && !res.found; k++) begin
            field = (word >> (k * nb)) & emask;
            if (field != 0) begin
              res.elem_out       = VAL_W'(field);
              res.found_position = IDX_W'(w * slots + k);
              res.found          = 1'b1;
            end
          end
        end
      end else begin
        woff = op.elem_index / slots;
        boff = (op.elem_index % slots) * nb;
        // Indexes that land past the last word read as zero and drop writes.
        if (woff < ROWS) begin
          word    = row_words[woff];
          shifted = ({32'd0, op.elem_value} & emask) << boff;
          case (op.func)
            FUNC_READ:  res.elem_out = VAL_W'((word >> boff) & emask);
            FUNC_WRITE: row_words[woff] = (word & ~(emask << boff)) | shifted;
            default:    row_words[woff] = word | shifted;
          endcase
        end
      end
      return res;
    endfunction

    function void note_item(in_item_t op);
      expected_results.push_back(predict_access(op));
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: elem_out %0h found_position %0h found %0b",
               got.elem_out, got.found_position, got.found);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      if (got.elem_out !== want.elem_out) begin
        $error("elem_out: expected %0h, actual %0h", want.elem_out, got.elem_out);
        errors++;
      end
      if (got.found_position !== want.found_position) begin
        $error("found_position: expected %0h, actual %0h",
               want.found_position, got.found_position);
        errors++;
      end
      if (got.found !== want.found) begin
        $error("found: expected %0b, actual %0b", want.found, got.found);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  pers_stream_if #(.T(in_item_t))          op_if ();
  pers_stream_if #(.T(out_item_t))         res_if ();
  pers_stream_if #(.T(logic [EB_W-1:0]))   cfg_if ();

  packed_element_row_store_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (op_if),
    .out_o  (res_if),
    .cfg_i  (cfg_if)
  );

  row_access_checker row_check = new();

  // When set, neither side inserts idle cycles for the current stretch of traffic.
  bit          steady;
  int unsigned sent_count;
  int unsigned cur_slots;
  int unsigned cycle_count;

  logic [EB_W-1:0] phase_widths [8] = '{6'd1, 6'd32, 6'd0, 6'd63, 6'd2, 6'd31, 6'd3, 6'd33};

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Offers one operation after a random idle gap (none while steady) and holds it until the transaction.
  task automatic push_op(func_e f, logic [IDX_W-1:0] idx, logic [VAL_W-1:0] val,
                         logic [LEN_W-1:0] len);
    in_item_t    op;
    int unsigned gap;
    op.func         = f;
    op.elem_index   = idx;
    op.elem_value   = val;
    op.length_words = len;
    gap = steady ? 0 : $urandom_range(0, 14);
    repeat (gap) begin
      op_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    op_if.valid <= 1'b1;
    op_if.data  <= op;
    do @(posedge clk_i); while (op_if.ready !== 1'b1);
    row_check.note_item(op);
    sent_count++;
    @(negedge clk_i);
  endtask

  // Stops offering operations and waits until every outstanding result has come back.
  task automatic settle();
    op_if.valid <= 1'b0;
    while (row_check.expected_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic load_element_bits(logic [EB_W-1:0] bits);
    int unsigned nb;
    settle();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= bits;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    row_check.width_reg = bits;
    nb = (bits == 0) ? 1 : (bits > MAX_EB) ? MAX_EB : bits;
    cur_slots = 64 / nb;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  // Most indexes fall in the first few words so that writes, reads and scans meet;
  // some cover the whole row and a few the full field, past the row end.
  function automatic logic [IDX_W-1:0] pick_index();
    int unsigned span;
    case ($urandom_range(0, 9))
      0:       return IDX_W'($urandom);
      1, 2:    span = cur_slots * ROWS;
      default: span = cur_slots * 32;
    endcase
    if (span > 65536) span = 65536;
    return IDX_W'($urandom_range(0, span - 1));
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  // Scans are mostly short; a few run over the full row or ask for more than it holds.
  function automatic logic [LEN_W-1:0] pick_length();
    case ($urandom_range(0, 19))
      0:          return LEN_W'($urandom_range(0, 2047));
      1, 2, 3, 4: return LEN_W'($urandom_range(0, 127));
      default:    return LEN_W'($urandom_range(0, 40));
    endcase
  endfunction

  initial begin : result_sink
    int unsigned stall;
    res_if.ready <= 1'b0;
    @(negedge clk_i);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 14);
      repeat (stall) begin
        res_if.ready <= 1'b0;
        @(negedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (res_if.valid !== 1'b1);
      row_check.check_result(res_if.data);
      @(negedge clk_i);
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    int unsigned     phase_goal, n;
    logic [IDX_W-1:0] idx;
    logic [EB_W-1:0]  bits;
    rst_ni       <= 1'b0;
    op_if.valid  <= 1'b0;
    op_if.data   <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data  <= '0;
    steady     = 1'b0;
    sent_count = 0;
    cur_slots  = 64;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // One-bit elements on an empty row: over-long and empty scans, the last element.
    load_element_bits(6'd1);
    push_op(FUNC_FIND, '0, '0, LEN_W'(2047));
    push_op(FUNC_FIND, '0, '0, LEN_W'(0));
    push_op(FUNC_READ, IDX_W'(65535), '0, '0);
    push_op(FUNC_WRITE, IDX_W'(65535), 32'hFFFF_FFFF, '0);
    push_op(FUNC_READ, IDX_W'(65535), '0, '0);
    push_op(FUNC_FIND, '0, '0, LEN_W'(1024));
    push_op(FUNC_FIND, '0, '0, LEN_W'(1023));
    push_op(FUNC_OR, IDX_W'(0), 32'h0000_0001, '0);
    push_op(FUNC_READ, IDX_W'(0), '0, '0);
    push_op(FUNC_FIND, '0, '0, LEN_W'(1));
    push_op(FUNC_WRITE, IDX_W'(0), '0, '0);

    // Widest elements: the last slot of the row, then indexes past the row end.
    load_element_bits(6'd32);
    push_op(FUNC_WRITE, IDX_W'(2047), 32'hFFFF_FFFF, '0);
    push_op(FUNC_READ, IDX_W'(2047), '0, '0);
    push_op(FUNC_WRITE, IDX_W'(2048), 32'h1234_5678, '0);
    push_op(FUNC_READ, IDX_W'(2048), '0, '0);
    push_op(FUNC_READ, IDX_W'(65535), '0, '0);
    push_op(FUNC_OR, IDX_W'(1), 32'hA5A5_A5A5, '0);
    push_op(FUNC_FIND, '0, '0, LEN_W'(1));

    // A zero width reads as one bit per element.
    load_element_bits(6'd0);
    push_op(FUNC_READ, IDX_W'(32), '0, '0);
    push_op(FUNC_FIND, '0, '0, LEN_W'(1));

    // An oversized width reads as 32 bits; leave only the top nibble of two words set.
    load_element_bits(6'd63);
    push_op(FUNC_READ, IDX_W'(1), '0, '0);
    push_op(FUNC_WRITE, IDX_W'(1), 32'hF000_0000, '0);
    push_op(FUNC_WRITE, IDX_W'(2047), 32'hF000_0000, '0);

    // Five-bit elements leave the top four bits unused, so the scan must miss.
    load_element_bits(6'd5);
    push_op(FUNC_FIND, '0, '0, LEN_W'(2047));
    push_op(FUNC_READ, IDX_W'(11), '0, '0);

    for (int p = 0; p < PHASES; p++) begin
      bits = (p < 8) ? phase_widths[p] : EB_W'($urandom_range(0, 63));
      load_element_bits(bits);
      phase_goal = sent_count + ITEM_TARGET / PHASES;
      while (sent_count < phase_goal) begin
        steady = ($urandom_range(0, 7) == 0);
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: begin
            // Store an element, then read it back.
            idx = pick_index();
            push_op($urandom_range(0, 1) ? FUNC_WRITE : FUNC_OR, idx, pick_value(),
                    pick_length());
            push_op(FUNC_READ, idx, pick_value(), pick_length());
          end
          5, 6: begin
            // Clear the head of the row and scan across the cleared words and just past.
            n = $urandom_range(1, 16);
            for (int e = 0; e < n; e++) push_op(FUNC_WRITE, IDX_W'(e), '0, pick_length());
            push_op(FUNC_FIND, pick_index(), pick_value(),
                    LEN_W'(n / cur_slots + $urandom_range(0, 1)));
          end
          default: begin
            push_op(func_e'($urandom_range(0, 3)), pick_index(), pick_value(),
                    pick_length());
          end
        endcase
      end
    end

    steady = 1'b0;
    settle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (row_check.expected_results.size() != 0) begin
      $error("%0d results never arrived", row_check.expected_results.size());
      row_check.errors++;
    end
    if (row_check.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
